// ===== hw/rtl/spmv_pkg.sv =====
// shared types, codes and fixed-point helpers for the csr spmv core
package spmv_pkg;

  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int ROW_W   = 16;
  localparam int ACC_W   = 64;

  // func codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_NONZERO = 2'd1;
  localparam logic [1:0] FUNC_CLOSE   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_BETA  = 2'd2;

  localparam logic signed [VALUE_W-1:0] ALPHA_RESET = 32'sh0001_0000;
  localparam logic signed [VALUE_W-1:0] BETA_RESET  = 32'sh0000_0000;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]   ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [ACC_W-1:0]   ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      clip;
  } red_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    clip;
  } sum_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_number;
    logic signed [VALUE_W-1:0] res;
    logic signed [VALUE_W-1:0] old;
    logic                      sat;
  } close_t;

  typedef struct packed {
    logic                      scaled;
    logic signed [VALUE_W-1:0] alpha;
    logic signed [VALUE_W-1:0] beta;
  } cfg_t;

  // 64-bit add clipped to the signed range
  function automatic sum_t sat_add64(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    sum_t r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    r.clip = s[ACC_W] != s[ACC_W-1];
    if (r.clip) begin
      r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // q32.32 to q16.16, round half up, clip to 32 bits
  function automatic red_t reduce_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-16:0] q;
    red_t r;
    t = {v[ACC_W-1], v} + 65'sd32768;
    q = t[ACC_W:16];
    r.clip = !((&q[ACC_W-16:VALUE_W-1]) || !(|q[ACC_W-16:VALUE_W-1]));
    if (r.clip) begin
      r.val = q[ACC_W-16] ? VAL_MIN : VAL_MAX;
    end else begin
      r.val = q[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/spmv_ram.sv =====
// generic single-port-write, registered-read ram
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/spmv_accum.sv =====
// vector store, product stage, row accumulator and row close stage
module spmv_accum #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int MAX_ROWS     = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [9:0]          in_index,
  input  logic signed [31:0]  in_value,
  output logic                cl_valid,
  input  logic                cl_ready,
  output spmv_pkg::close_t    cl_data
);

  import spmv_pkg::*;

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int RW = $clog2(MAX_ROWS);

  logic                      accept;
  logic                      in_hit;
  logic [AW-1:0]             in_addr;
  logic                      free1, free2, free3, fire2;

  logic                      r1_valid;
  logic [1:0]                r1_func;
  logic                      r1_hit;
  logic signed [VALUE_W-1:0] r1_value;
  logic signed [VALUE_W-1:0] r1_entry;
  logic signed [ACC_W-1:0]   prod;

  logic                      r2_valid;
  logic                      r2_close;
  logic signed [ACC_W-1:0]   r2_prod;
  logic signed [VALUE_W-1:0] r2_old;

  logic signed [ACC_W-1:0]   acc;
  logic                      ovf;
  logic [RW-1:0]             row_cnt;
  logic [RW-1:0]             row_cnt_next;
  sum_t                      acc_sum;
  red_t                      acc_red;

  assign free3    = !cl_valid || cl_ready;
  assign fire2    = r2_valid && (!r2_close || free3);
  assign free2    = !r2_valid || fire2;
  assign free1    = !r1_valid || free2;
  assign in_ready = free1;
  assign accept   = in_valid && free1;

  assign in_hit  = 32'(in_index) < 32'(VECTOR_DEPTH);
  assign in_addr = AW'(in_index);

  spmv_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(VECTOR_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && in_func == FUNC_LOAD && in_hit),
    .waddr(in_addr),
    .wdata(in_value),
    .re   (accept),
    .raddr(in_addr),
    .rdata(r1_entry)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (free1) begin
      r1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r1_func  <= in_func;
      r1_hit   <= in_hit;
      r1_value <= in_value;
    end
  end

  assign prod = 64'(r1_value) * 64'(r1_entry);

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (free2) begin
      r2_valid <= r1_valid && (r1_func == FUNC_NONZERO || r1_func == FUNC_CLOSE);
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && r1_valid) begin
      r2_close <= r1_func == FUNC_CLOSE;
      r2_prod  <= r1_hit ? prod : '0;
      r2_old   <= r1_value;
    end
  end

  assign acc_sum = sat_add64(acc, r2_prod);
  assign acc_red = reduce_q(acc);

  always_comb begin
    if (row_cnt == RW'(MAX_ROWS - 1)) begin
      row_cnt_next = '0;
    end else begin
      row_cnt_next = row_cnt + RW'(1);
    end
  end

  // accumulator and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      ovf     <= 1'b0;
      row_cnt <= '0;
    end else if (fire2) begin
      if (r2_close) begin
        acc     <= '0;
        ovf     <= 1'b0;
        row_cnt <= row_cnt_next;
      end else begin
        acc <= acc_sum.val;
        if (acc_sum.clip) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  // close register
  always_ff @(posedge clk) begin
    if (rst) begin
      cl_valid <= 1'b0;
    end else if (free3) begin
      cl_valid <= r2_valid && r2_close;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && r2_valid && r2_close) begin
      cl_data.row_number <= ROW_W'(row_cnt);
      cl_data.res        <= acc_red.val;
      cl_data.old        <= r2_old;
      cl_data.sat        <= ovf || acc_red.clip;
    end
  end

endmodule

// ===== hw/rtl/spmv_scale.sv =====
// alpha/beta scaling stages and result register
module spmv_scale (
  input  logic                clk,
  input  logic                rst,
  input  spmv_pkg::cfg_t      cfg,
  input  logic                cl_valid,
  output logic                cl_ready,
  input  spmv_pkg::close_t    cl_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_row,
  output logic signed [31:0]  out_result,
  output logic                out_sat
);

  import spmv_pkg::*;

  logic                      free4, free5, free_o;

  logic                      r4_valid;
  logic [ROW_W-1:0]          r4_row;
  logic signed [VALUE_W-1:0] r4_res;
  logic                      r4_sat;
  logic signed [ACC_W-1:0]   r4_t1;
  logic signed [ACC_W-1:0]   r4_t2;

  logic                      r5_valid;
  logic [ROW_W-1:0]          r5_row;
  logic signed [VALUE_W-1:0] r5_res;
  logic                      r5_sat;
  sum_t                      r5_sum;

  red_t                      fin_red;

  assign free_o   = !out_valid || out_ready;
  assign free5    = !r5_valid || free_o;
  assign free4    = !r4_valid || free5;
  assign cl_ready = free4;

  // gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      r4_valid <= 1'b0;
    end else if (free4) begin
      r4_valid <= cl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free4 && cl_valid) begin
      r4_row <= cl_data.row_number;
      r4_res <= cl_data.res;
      r4_sat <= cl_data.sat;
      r4_t1  <= 64'(cfg.alpha) * 64'(cl_data.res);
      r4_t2  <= 64'(cfg.beta) * 64'(cl_data.old);
    end
  end

  // sum of scaled terms
  always_ff @(posedge clk) begin
    if (rst) begin
      r5_valid <= 1'b0;
    end else if (free5) begin
      r5_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free5 && r4_valid) begin
      r5_row <= r4_row;
      r5_res <= r4_res;
      r5_sat <= r4_sat;
      r5_sum <= sat_add64(r4_t1, r4_t2);
    end
  end

  assign fin_red = reduce_q(r5_sum.val);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free_o) begin
      out_valid <= r5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_o && r5_valid) begin
      out_row <= r5_row;
      if (cfg.scaled) begin
        out_result <= fin_red.val;
        out_sat    <= r5_sat || r5_sum.clip || fin_red.clip;
      end else begin
        out_result <= r5_res;
        out_sat    <= r5_sat;
      end
    end
  end

endmodule

// ===== hw/rtl/csr_sparse_matrix_vector_multiply_core.sv =====
// csr sparse matrix-vector multiply core, top level
//
// Input stream (s_*): one beat per item. s_tuser holds the function code:
// load vector entry, matrix nonzero, or close row. Loads fill the vector
// store, nonzeros multiply by the stored entry and accumulate into the row,
// a close carries the row's old output value and produces one result beat.
// Output stream (m_*): one beat per closed row with row number, result and
// a saturation flag. The apb port sets plain or scaled mode and the alpha
// and beta gains; write it only while no item is in flight.
// Throughput: one item per cycle while s_tready is high, loads and nonzeros back to back; the
// vector store has one write and one read port, both used at acceptance.
// A close goes through the input, product, close, gain, sum and result
// registers (store read, product, reduce, gain multiply, sum, reduce).
// Reset clears the pipeline, the accumulator, the row counter and loads
// the register defaults; the vector store is not cleared.
// When m_tready is low the output beat holds; earlier stages keep taking
// items until the bubbles in the pipeline are used up, then s_tready drops.
module csr_sparse_matrix_vector_multiply_core #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = spmv_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // index[9:0], value[41:10], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // row_number[15:0], row_result[47:16]
  output logic [0:0]  m_tuser,   // saturated[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import spmv_pkg::*;

  logic                      scaled_mode;
  logic signed [VALUE_W-1:0] alpha_gain;
  logic signed [VALUE_W-1:0] beta_gain;
  logic                      cfg_wr;
  cfg_t                      cfg;

  logic                      cl_valid;
  logic                      cl_ready;
  close_t                    cl_data;
  logic [ROW_W-1:0]          out_row;
  logic signed [VALUE_W-1:0] out_result;
  logic                      out_sat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_mode <= 1'b0;
      alpha_gain  <= ALPHA_RESET;
      beta_gain   <= BETA_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:  scaled_mode <= pwdata[0];
        REG_ALPHA: alpha_gain  <= pwdata;
        REG_BETA:  beta_gain   <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {31'd0, scaled_mode};
      REG_ALPHA: prdata = alpha_gain;
      REG_BETA:  prdata = beta_gain;
      default:   prdata = '0;
    endcase
  end

  assign cfg.scaled = scaled_mode;
  assign cfg.alpha  = alpha_gain;
  assign cfg.beta   = beta_gain;

  spmv_accum #(
    .VECTOR_DEPTH(VECTOR_DEPTH),
    .MAX_ROWS    (MAX_ROWS)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_func (s_tuser),
    .in_index(s_tdata[INDEX_W-1:0]),
    .in_value(s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .cl_valid(cl_valid),
    .cl_ready(cl_ready),
    .cl_data (cl_data)
  );

  spmv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cl_valid  (cl_valid),
    .cl_ready  (cl_ready),
    .cl_data   (cl_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_result(out_result),
    .out_sat   (out_sat)
  );

  assign m_tdata = {out_result, out_row};
  assign m_tuser = out_sat;

  // an empty result register means every stage can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_alpha_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[3:2] == REG_ALPHA) |=> alpha_gain == $past(pwdata))
    else $error("alpha gain write lost");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule
